/* src/lzwd_pkg.sv */
// shared types and constants for the lzss window-64 decompressor
package lzwd_pkg;

  localparam int WINDOW     = 64;
  localparam int HIST_AW    = $clog2(WINDOW);
  localparam int COUNT_BITS = 24;
  localparam int LEN_BITS   = 24;
  localparam int RUN_BITS   = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_FLAG,
    KIND_LITERAL,
    KIND_REF
  } kind_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
    logic  run_end;
  } status_t;

endpackage

/* src/lzwd_ctrl.sv */
// controller state machine: input acceptance, history read and byte emission sequencing
module lzwd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lzwd_pkg::status_t status,
  output lzwd_pkg::cmd_t    cmd
);

  lzwd_pkg::state_t state_r;
  lzwd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzwd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzwd_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.kind == lzwd_pkg::KIND_LITERAL) begin
            state_nxt = lzwd_pkg::ST_EMIT;
          end else if (status.kind == lzwd_pkg::KIND_REF) begin
            state_nxt = lzwd_pkg::ST_READ;
          end
        end
      end
      lzwd_pkg::ST_READ: begin
        state_nxt = lzwd_pkg::ST_EMIT;
      end
      lzwd_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = status.run_end ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = lzwd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd     = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state_r)
      lzwd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lzwd_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      lzwd_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* src/lzwd_dp.sv */
// datapath: parse state, history memory with valid bits, counters and output register
module lzwd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lzwd_pkg::LEN_BITS-1:0] cfg_wr_data,
  input  logic [7:0]                    in_byte,
  input  logic                          in_new_stream,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last_of_run,
  output logic                          out_stream_done,
  input  lzwd_pkg::cmd_t                cmd,
  output lzwd_pkg::status_t             status
);

  logic [lzwd_pkg::LEN_BITS-1:0]   expected_r;
  logic                            expect_flag_r;
  logic [7:0]                      group_flags_r;
  logic [2:0]                      item_idx_r;
  logic [lzwd_pkg::HIST_AW-1:0]    ptr_r;
  logic [lzwd_pkg::COUNT_BITS-1:0] count_r;
  logic [lzwd_pkg::WINDOW-1:0]     valid_r;
  logic [lzwd_pkg::RUN_BITS-1:0]   remain_r;
  logic [lzwd_pkg::HIST_AW-1:0]    dist_code_r;
  logic                            is_ref_r;
  logic [7:0]                      lit_r;
  logic [7:0]                      mem_q_r;
  logic                            rd_valid_r;
  logic                            out_valid_r;
  logic [7:0]                      out_byte_r;
  logic                            out_last_r;
  logic                            out_done_r;

  logic [7:0] hist_mem [lzwd_pkg::WINDOW];

  // state as seen by the incoming byte, after an optional stream restart
  logic                            expect_eff;
  logic [7:0]                      flags_eff;
  logic [2:0]                      idx_eff;
  logic [lzwd_pkg::COUNT_BITS-1:0] count_eff;
  logic                            complete;
  lzwd_pkg::kind_t                 kind;

  logic [lzwd_pkg::HIST_AW-1:0]    rd_addr;
  logic [7:0]                      emit_byte;
  logic [lzwd_pkg::COUNT_BITS-1:0] count_inc;
  logic                            done_after;

  always_comb begin
    expect_eff = in_new_stream | expect_flag_r;
    flags_eff  = in_new_stream ? 8'd0 : group_flags_r;
    idx_eff    = in_new_stream ? 3'd0 : item_idx_r;
    count_eff  = in_new_stream ? '0 : count_r;
    complete   = count_eff >= lzwd_pkg::COUNT_BITS'(expected_r);
    if (complete) begin
      kind = lzwd_pkg::KIND_IGNORE;
    end else if (expect_eff) begin
      kind = lzwd_pkg::KIND_FLAG;
    end else if (flags_eff[idx_eff]) begin
      kind = lzwd_pkg::KIND_REF;
    end else begin
      kind = lzwd_pkg::KIND_LITERAL;
    end
  end

  // distance minus one is the code, so pointer minus distance is pointer plus its complement
  assign rd_addr   = ptr_r + ~dist_code_r;
  assign emit_byte = is_ref_r ? (rd_valid_r ? mem_q_r : 8'd0) : lit_r;
  assign count_inc = (count_r == lzwd_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
  assign done_after = count_inc >= lzwd_pkg::COUNT_BITS'(expected_r);

  assign status.kind     = kind;
  assign status.out_free = !out_valid_r || out_ready;
  assign status.run_end  = (remain_r == lzwd_pkg::RUN_BITS'(1)) || done_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
    end else if (cfg_wr_en) begin
      expected_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_flag_r <= 1'b1;
      group_flags_r <= 8'd0;
      item_idx_r    <= 3'd0;
      ptr_r         <= '0;
      count_r       <= '0;
      valid_r       <= '0;
      remain_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        expect_flag_r <= expect_eff;
        group_flags_r <= flags_eff;
        item_idx_r    <= idx_eff;
        count_r       <= count_eff;
        if (in_new_stream) begin
          ptr_r   <= '0;
          valid_r <= '0;
        end
        unique case (kind)
          lzwd_pkg::KIND_FLAG: begin
            group_flags_r <= in_byte;
            item_idx_r    <= 3'd0;
            expect_flag_r <= 1'b0;
          end
          lzwd_pkg::KIND_LITERAL: begin
            item_idx_r    <= idx_eff + 3'd1;
            expect_flag_r <= (idx_eff == 3'd7);
            remain_r      <= lzwd_pkg::RUN_BITS'(1);
          end
          lzwd_pkg::KIND_REF: begin
            item_idx_r    <= idx_eff + 3'd1;
            expect_flag_r <= (idx_eff == 3'd7);
            remain_r      <= lzwd_pkg::RUN_BITS'({1'b0, in_byte[1:0]}) + 3'd2;
          end
          default: begin
            remain_r <= remain_r;
          end
        endcase
      end
      if (cmd.emit) begin
        valid_r[ptr_r] <= 1'b1;
        ptr_r          <= ptr_r + 1'b1;
        count_r        <= count_inc;
        remain_r       <= remain_r - 1'b1;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dist_code_r <= in_byte[7:2];
      is_ref_r    <= (kind == lzwd_pkg::KIND_REF);
      lit_r       <= in_byte;
    end
    if (cmd.rd) begin
      rd_valid_r <= valid_r[rd_addr];
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= status.run_end;
      out_done_r <= done_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hist_mem[ptr_r] <= emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_stream_done = out_done_r;

endmodule

/* src/lzss_window64_decompressor_top.sv */
// top level of the lzss window-64 decompressor: controller, datapath and checks
//
//   channel | direction | ports                                   | handshake
//   in      | input     | in_byte, in_new_stream                  | in_valid / in_ready
//   out     | output    | out_byte, out_last_of_run, out_stream_done | out_valid / out_ready
//   cfg     | input     | cfg_wr_data (expected_length)           | cfg_wr_en, no wait
//
// a flag or ignored byte is only accepted, a literal then takes the emit state, and each of
// the n bytes of a back-reference needs a registered history read, then a write
// reset is synchronous, active low; history starts cleared through per-entry valid bits
// in_ready is high only while the controller is idle; a full output register stalls
// emission until out_ready, the transaction stays in the output register meanwhile
module lzss_window64_decompressor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lzwd_pkg::LEN_BITS-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_new_stream,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last_of_run,
  output logic                          out_stream_done
);

  lzwd_pkg::cmd_t    cmd;
  lzwd_pkg::status_t status;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lzwd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_byte         (in_byte),
    .in_new_stream   (in_new_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_stream_done (out_stream_done),
    .cmd             (cmd),
    .status          (status)
  );

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("byte emitted into a full output register");

  a_ref_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && status.kind == lzwd_pkg::KIND_REF) |=> (!in_ready && cmd.rd))
    else $error("back-reference did not start a history read");

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !in_ready)
    else $error("input taken between history read and emission");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted byte not presented on the output");

endmodule
